// ----- rtl/bpcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcd_pkg
// Shared constants and types of the button press confirm debouncer.
// ----------------------------------------------------------------------------
package bpcd_pkg;

  // Sizes of the block.
  localparam int unsigned NUM_BUTTONS   = 3;
  localparam int unsigned LEVEL_FIELDS  = 3;
  localparam int unsigned COUNT_WIDTH   = 8;
  localparam int unsigned TIMER_WIDTH   = 16;
  localparam int unsigned SEL_WIDTH     = 2;
  localparam int unsigned MASK_WIDTH    = 3;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_DATA_WIDTH  = 8;
  localparam int unsigned OUT_DATA_WIDTH = 16;

  // Configuration port.
  localparam int unsigned APB_ADDR_WIDTH = 3;
  localparam int unsigned APB_DATA_WIDTH = 32;

  // Reset value of the confirm time.
  localparam logic [TIMER_WIDTH-1:0] CONFIRM_RESET = TIMER_WIDTH'(30);

  // Kind of an input item.
  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_TAKE = 1'b1
  } kind_e;

  // Register index, taken from address bit 2.
  typedef enum logic {
    REG_CONFIRM_TICKS   = 1'b0,
    REG_ACTIVE_LOW_MASK = 1'b1
  } reg_idx_e;

  // Per-lane control for one accepted item.
  typedef struct packed {
    logic tick;
    logic take;
    logic active;
  } lane_ctrl_t;

endpackage

// ----- rtl/bpcd_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcd_lane
// Debounce and press-confirm core of one button, with its saturating count.
// ----------------------------------------------------------------------------
module bpcd_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpcd_pkg::lane_ctrl_t                ctrl_i,
  input  logic [bpcd_pkg::TIMER_WIDTH-1:0]    load_i,
  output logic [bpcd_pkg::COUNT_WIDTH-1:0]    count_o
);
  import bpcd_pkg::*;

  logic                   last_q, last_d;
  logic                   await_q, await_d;
  logic                   run_q, run_d;
  logic [TIMER_WIDTH-1:0] cd_q, cd_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [TIMER_WIDTH-1:0] cd_dec;

  assign cd_dec = cd_q - TIMER_WIDTH'(1);

  // Edge check first; without an edge a running countdown steps and may expire.
  always_comb begin
    last_d  = last_q;
    await_d = await_q;
    run_d   = run_q;
    cd_d    = cd_q;
    cnt_d   = cnt_q;
    if (ctrl_i.tick) begin
      if (ctrl_i.active != last_q) begin
        last_d = ctrl_i.active;
        if (!(ctrl_i.active && await_q)) begin
          cd_d  = load_i;
          run_d = 1'b1;
        end
      end else if (run_q) begin
        cd_d = cd_dec;
        if (cd_dec == '0) begin
          run_d = 1'b0;
          if (!ctrl_i.active) begin
            await_d = 1'b0;
          end else if (!await_q) begin
            await_d = 1'b1;
            if (cnt_q != '1) begin
              cnt_d = cnt_q + COUNT_WIDTH'(1);
            end
          end
        end
      end
    end
    // A take of this button clears its count.
    if (ctrl_i.take) begin
      cnt_d = '0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      await_q <= 1'b0;
      run_q   <= 1'b0;
      cd_q    <= '0;
      cnt_q   <= '0;
    end else begin
      last_q  <= last_d;
      await_q <= await_d;
      run_q   <= run_d;
      cd_q    <= cd_d;
      cnt_q   <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

// ----- rtl/bpcd_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcd_merge
// Picks the selected lane's count on a take and holds it in the output
// register until the downstream side takes it.
// ----------------------------------------------------------------------------
module bpcd_merge (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic [bpcd_pkg::NUM_BUTTONS-1:0][bpcd_pkg::COUNT_WIDTH-1:0] counts_i,
  input  logic                                                 take_i,
  input  logic [bpcd_pkg::SEL_WIDTH-1:0]                       select_i,
  input  logic                                                 out_ready_i,
  output logic                                                 in_ready_o,
  output logic                                                 out_valid_o,
  output logic [bpcd_pkg::COUNT_WIDTH-1:0]                     out_count_o,
  output logic [bpcd_pkg::SEL_WIDTH-1:0]                       out_echo_o
);
  import bpcd_pkg::*;

  logic                   valid_q, valid_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [SEL_WIDTH-1:0]   echo_q, echo_d;
  logic [COUNT_WIDTH-1:0] picked;

  // A select past the last button reads as zero.
  always_comb begin
    picked = '0;
    for (int unsigned b = 0; b < NUM_BUTTONS; b++) begin
      if (select_i == SEL_WIDTH'(b)) begin
        picked = counts_i[b];
      end
    end
  end

  // The output register frees up whenever its item is taken.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    echo_d  = echo_q;
    if (in_ready_o) begin
      valid_d = take_i;
      if (take_i) begin
        count_d = picked;
        echo_d  = select_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    echo_q  <= echo_d;
  end

  assign out_valid_o = valid_q;
  assign out_count_o = count_q;
  assign out_echo_o  = echo_q;

endmodule

// ----- rtl/button_press_confirm_debouncer.sv -----
`timescale 1ns / 1ps
// Results: a take item's result is registered and shown on the master side in
// the cycle after the item is accepted; tick items give no result.
// Throughput: one item per cycle; the single output register stalls input
// only while its result waits on a low m_axis_tready.
// Reset: asynchronous, active low; counts, timers and flags clear, confirm
// time returns to 30 ticks and the polarity mask to zero.
// ----------------------------------------------------------------------------
// button_press_confirm_debouncer
// Three button debouncer with press confirmation, one lane per button and a
// merging stage that returns one button's count on a take.
// ----------------------------------------------------------------------------
module button_press_confirm_debouncer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] level_power, [1] level_left, [2] level_right, [4:3] button_select
  input  logic [bpcd_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,
  // [0] kind
  input  logic                                   s_axis_tuser,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [7:0] event_count, [9:8] button_echo
  output logic [bpcd_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bpcd_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [bpcd_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [bpcd_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                   pready
);
  import bpcd_pkg::*;

  logic [TIMER_WIDTH-1:0] confirm_q, confirm_d;
  logic [MASK_WIDTH-1:0]  mask_q, mask_d;
  logic                   cfg_wr;
  reg_idx_e               reg_idx;

  logic                   accept;
  logic                   is_take;
  logic [LEVEL_FIELDS-1:0] raw_levels;
  logic [SEL_WIDTH-1:0]   select;
  logic [TIMER_WIDTH-1:0] load;
  logic [NUM_BUTTONS-1:0][COUNT_WIDTH-1:0] counts;
  logic [COUNT_WIDTH-1:0] out_count;
  logic [SEL_WIDTH-1:0]   out_echo;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    confirm_d = confirm_q;
    mask_d    = mask_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_CONFIRM_TICKS:   confirm_d = pwdata[TIMER_WIDTH-1:0];
        REG_ACTIVE_LOW_MASK: mask_d    = pwdata[MASK_WIDTH-1:0];
        default:             confirm_d = confirm_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      confirm_q <= CONFIRM_RESET;
      mask_q    <= '0;
    end else begin
      confirm_q <= confirm_d;
      mask_q    <= mask_d;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_CONFIRM_TICKS:   prdata = APB_DATA_WIDTH'(confirm_q);
      REG_ACTIVE_LOW_MASK: prdata = APB_DATA_WIDTH'(mask_q);
      default:             prdata = '0;
    endcase
  end

  // Input item decode.
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_take    = (kind_e'(s_axis_tuser) == KIND_TAKE);
  assign raw_levels = s_axis_tdata[LEVEL_FIELDS-1:0];
  assign select     = s_axis_tdata[LEVEL_FIELDS +: SEL_WIDTH];

  // A zero confirm time still waits one tick.
  assign load = (confirm_q == '0) ? TIMER_WIDTH'(1) : confirm_q;

  // One lane per button.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    lane_ctrl_t ctrl;
    logic       raw;
    logic       inv;

    if (b < LEVEL_FIELDS) begin : g_pin
      assign raw = raw_levels[b];
      assign inv = mask_q[b];
    end else begin : g_nopin
      assign raw = 1'b0;
      assign inv = 1'b0;
    end

    assign ctrl.tick   = accept && !is_take;
    assign ctrl.take   = accept && is_take && (select == SEL_WIDTH'(b));
    assign ctrl.active = raw ^ inv;

    bpcd_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .load_i  (load),
      .count_o (counts[b])
    );
  end

  // Merge and output register.
  bpcd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .counts_i    (counts),
    .take_i      (accept && is_take),
    .select_i    (select),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_count_o (out_count),
    .out_echo_o  (out_echo)
  );

  assign m_axis_tdata = OUT_DATA_WIDTH'({out_echo, out_count});

endmodule

// ----- rtl/bpcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcd_checker
// Port-level checks of the debouncer's streams, bound to the top level.
// ----------------------------------------------------------------------------
module bpcd_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [bpcd_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
  input logic                                s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [bpcd_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);
  import bpcd_pkg::*;

  // A result that waits keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // With no result pending, input is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A take item gives a result next cycle carrying its select.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
      m_axis_tvalid && (m_axis_tdata[9:8] == $past(s_axis_tdata[4:3])))
    else $error("take item without matching result");

  // A tick item on an idle output gives no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=>
      !m_axis_tvalid)
    else $error("tick item produced a result");

  // An out-of-range select always returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:8] == 2'd3) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero count for unknown button");

endmodule

bind button_press_confirm_debouncer bpcd_checker u_bpcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
